// ----- design/rhb_pkg.sv -----
package rhb_pkg;

   // Operating modes held in the mode register.
   localparam logic [1:0] MODE_TO_HSV   = 2'd0;
   localparam logic [1:0] MODE_TO_RGB   = 2'd1;
   localparam logic [1:0] MODE_BRIGHTEN = 2'd2;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   // Register indexes on the write port.
   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_GAIN = 1'b1;

   // Which channel holds the maximum; picks the hue sector base.
   localparam logic [1:0] BASE_RED   = 2'd0;
   localparam logic [1:0] BASE_GREEN = 2'd1;
   localparam logic [1:0] BASE_BLUE  = 2'd2;

   // Fixed-point formats: hue is degrees times 64, saturation is Q1.12.
   localparam logic [11:0] HUE_UNIT = 12'd3840;
   localparam logic [14:0] HUE_FULL = 15'd23040;
   localparam logic [12:0] SAT_ONE  = 13'd4096;

   // Denominator of the q and t terms is SAT_ONE times HUE_UNIT = 15 * 2^20.
   localparam logic [23:0] RGB_DEN      = 24'd15728640;
   localparam logic [31:0] RGB_HALF_DEN = 32'd7864320;
   // Reciprocal of 15 scaled by 2^19, exact for the numerators that occur.
   localparam logic [15:0] INV15        = 16'd34953;

   // Divider geometry: the numerator splits into DIV_DEN_W top bits that
   // seed the remainder and DIV_QUO_W bits that are shifted in one per stage.
   localparam int DIV_DEN_W = 8;
   localparam int DIV_QUO_W = 13;
   localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;

   localparam int RGB_STAGES = 8;

   typedef struct packed {
      logic [1:0]  mode;
      logic        grey;
      logic [7:0]  val;
      logic [1:0]  base;
      logic        neg;
      logic [14:0] x;
      logic [12:0] y;
      logic [7:0]  z;
   } hsv_side_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        flag;
      logic [14:0] hue;
      logic [12:0] sat;
      logic [7:0]  val;
   } pix_side_type;

   function automatic logic [14:0] hue_base(input logic [1:0] code);
      logic [14:0] res;
      case (code)
         BASE_RED:   res = 15'd0;
         BASE_GREEN: res = 15'd7680;
         BASE_BLUE:  res = 15'd15360;
         default:    res = 15'd0;
      endcase
      return res;
   endfunction

   function automatic logic [14:0] sector_base(input logic [2:0] sec);
      logic [14:0] res;
      case (sec)
         3'd0:    res = 15'd0;
         3'd1:    res = 15'd3840;
         3'd2:    res = 15'd7680;
         3'd3:    res = 15'd11520;
         3'd4:    res = 15'd15360;
         default: res = 15'd19200;
      endcase
      return res;
   endfunction

endpackage

// ----- design/rhb_div_pipe.sv -----
module rhb_div_pipe import rhb_pkg::*; #(
   parameter int PW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic [DIV_NUM_W-1:0] in_num_a,
   input  logic [DIV_DEN_W-1:0] in_den_a,
   input  logic [DIV_NUM_W-1:0] in_num_b,
   input  logic [DIV_DEN_W-1:0] in_den_b,
   input  logic [PW-1:0]        in_side,
   output logic                 out_vld,
   output logic [DIV_QUO_W-1:0] out_quo_a,
   output logic [DIV_QUO_W-1:0] out_quo_b,
   output logic [PW-1:0]        out_side
);

   localparam int DW = DIV_DEN_W;
   localparam int QW = DIV_QUO_W;

   // One restoring step: shift in the next numerator bit, subtract if it fits.
   // The low word carries unused numerator bits and collects quotient bits.
   function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] rem,
                                                 input logic [QW-1:0] lq,
                                                 input logic [DW-1:0] den);
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_nx;
      trial  = {rem, lq[QW-1]};
      diff   = trial - {1'b0, den};
      ge     = (trial >= {1'b0, den});
      rem_nx = ge ? diff[DW-1:0] : trial[DW-1:0];
      return {rem_nx, lq[QW-2:0], ge};
   endfunction

   logic          vld_ff   [QW];
   logic [DW-1:0] rem_a_ff [QW];
   logic [DW-1:0] rem_b_ff [QW];
   logic [QW-1:0] lq_a_ff  [QW];
   logic [QW-1:0] lq_b_ff  [QW];
   logic [DW-1:0] den_a_ff [QW];
   logic [DW-1:0] den_b_ff [QW];
   logic [PW-1:0] side_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          vld_p;
      logic [DW-1:0] rem_a_p, rem_b_p, den_a_p, den_b_p;
      logic [QW-1:0] lq_a_p, lq_b_p;
      logic [PW-1:0] side_p;
      logic [DW+QW-1:0] step_a_in, step_b_in;

      if (k == 0) begin : g_first
         assign vld_p   = in_vld;
         assign rem_a_p = in_num_a[DIV_NUM_W-1:QW];
         assign lq_a_p  = in_num_a[QW-1:0];
         assign rem_b_p = in_num_b[DIV_NUM_W-1:QW];
         assign lq_b_p  = in_num_b[QW-1:0];
         assign den_a_p = in_den_a;
         assign den_b_p = in_den_b;
         assign side_p  = in_side;
      end else begin : g_next
         assign vld_p   = vld_ff[k-1];
         assign rem_a_p = rem_a_ff[k-1];
         assign lq_a_p  = lq_a_ff[k-1];
         assign rem_b_p = rem_b_ff[k-1];
         assign lq_b_p  = lq_b_ff[k-1];
         assign den_a_p = den_a_ff[k-1];
         assign den_b_p = den_b_ff[k-1];
         assign side_p  = side_ff[k-1];
      end

      assign step_a_in = div_step(rem_a_p, lq_a_p, den_a_p);
      assign step_b_in = div_step(rem_b_p, lq_b_p, den_b_p);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_p;
         end
         rem_a_ff[k] <= step_a_in[DW+QW-1:QW];
         lq_a_ff[k]  <= step_a_in[QW-1:0];
         rem_b_ff[k] <= step_b_in[DW+QW-1:QW];
         lq_b_ff[k]  <= step_b_in[QW-1:0];
         den_a_ff[k] <= den_a_p;
         den_b_ff[k] <= den_b_p;
         side_ff[k]  <= side_p;
      end
   end

   assign out_vld   = vld_ff[QW-1];
   assign out_quo_a = lq_a_ff[QW-1];
   assign out_quo_b = lq_b_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ----- design/rhb_hsv2rgb.sv -----
module rhb_hsv2rgb import rhb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_vld,
   input  logic [14:0]  in_hue,
   input  logic [12:0]  in_sat,
   input  logic [7:0]   in_val,
   input  pix_side_type in_side,
   output logic         out_vld,
   output logic [7:0]   out_red,
   output logic [7:0]   out_green,
   output logic [7:0]   out_blue,
   output pix_side_type out_side
);

   logic         vld_ff  [RGB_STAGES];
   pix_side_type side_ff [RGB_STAGES];

   // Stage 1: wrap hue into one circle, clamp saturation.
   logic [14:0] r1_h_ff;
   logic [12:0] r1_s_ff;
   logic [7:0]  r1_v_ff;
   logic        r1_zero_ff;
   // Stage 2: sector and remainder within the sector.
   logic [2:0]  r2_sec_ff, r2_sec_in;
   logic [11:0] r2_rem_ff;
   logic [12:0] r2_s_ff, r2_sinv_ff;
   logic [7:0]  r2_v_ff;
   logic        r2_zero_ff;
   logic [14:0] r2_rem_in;
   // Stage 3: saturation products.
   logic [24:0] r3_pq_ff, r3_pt_ff;
   logic [20:0] r3_pn_ff;
   logic [2:0]  r3_sec_ff;
   logic [7:0]  r3_v_ff;
   logic        r3_zero_ff;
   logic [20:0] r4_pn_in;
   // Stage 4: one minus products, and p finished.
   logic [23:0] r4_dq_ff, r4_dt_ff;
   logic [7:0]  r4_p_ff, r4_v_ff;
   logic [2:0]  r4_sec_ff;
   logic        r4_zero_ff;
   // Stage 5: scaled by value.
   logic [31:0] r5_xq_ff, r5_xt_ff;
   logic [7:0]  r5_p_ff, r5_v_ff;
   logic [2:0]  r5_sec_ff;
   logic        r5_zero_ff;
   logic [31:0] r6_sq_in, r6_st_in;
   // Stage 6: rounded and divided by 2^20.
   logic [11:0] r6_nq_ff, r6_nt_ff;
   logic [7:0]  r6_p_ff, r6_v_ff;
   logic [2:0]  r6_sec_ff;
   logic        r6_zero_ff;
   logic [27:0] r7_mq_in, r7_mt_in;
   // Stage 7: divided by 15.
   logic [7:0]  r7_q_ff, r7_t_ff, r7_p_ff, r7_v_ff;
   logic [2:0]  r7_sec_ff;
   logic        r7_zero_ff;
   // Stage 8: colors placed by sector.
   logic [7:0]  r8_r_ff, r8_g_ff, r8_b_ff;
   logic [7:0]  r8_r_in, r8_g_in, r8_b_in;

   always_comb begin
      if (r1_h_ff < 15'd3840) begin
         r2_sec_in = 3'd0;
      end else if (r1_h_ff < 15'd7680) begin
         r2_sec_in = 3'd1;
      end else if (r1_h_ff < 15'd11520) begin
         r2_sec_in = 3'd2;
      end else if (r1_h_ff < 15'd15360) begin
         r2_sec_in = 3'd3;
      end else if (r1_h_ff < 15'd19200) begin
         r2_sec_in = 3'd4;
      end else begin
         r2_sec_in = 3'd5;
      end
   end

   assign r2_rem_in = r1_h_ff - sector_base(r2_sec_in);
   assign r4_pn_in  = r3_pn_ff + 21'd2048;
   assign r6_sq_in  = r5_xq_ff + RGB_HALF_DEN;
   assign r6_st_in  = r5_xt_ff + RGB_HALF_DEN;
   assign r7_mq_in  = {4'd0, r6_nq_ff} * {12'd0, INV15};
   assign r7_mt_in  = {4'd0, r6_nt_ff} * {12'd0, INV15};

   always_comb begin
      if (r7_zero_ff) begin
         r8_r_in = r7_v_ff;
         r8_g_in = r7_v_ff;
         r8_b_in = r7_v_ff;
      end else begin
         case (r7_sec_ff)
            3'd0: begin
               r8_r_in = r7_v_ff; r8_g_in = r7_t_ff; r8_b_in = r7_p_ff;
            end
            3'd1: begin
               r8_r_in = r7_q_ff; r8_g_in = r7_v_ff; r8_b_in = r7_p_ff;
            end
            3'd2: begin
               r8_r_in = r7_p_ff; r8_g_in = r7_v_ff; r8_b_in = r7_t_ff;
            end
            3'd3: begin
               r8_r_in = r7_p_ff; r8_g_in = r7_q_ff; r8_b_in = r7_v_ff;
            end
            3'd4: begin
               r8_r_in = r7_t_ff; r8_g_in = r7_p_ff; r8_b_in = r7_v_ff;
            end
            default: begin
               r8_r_in = r7_v_ff; r8_g_in = r7_p_ff; r8_b_in = r7_q_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RGB_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < RGB_STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      side_ff[0] <= in_side;
      for (int i = 1; i < RGB_STAGES; i++) begin
         side_ff[i] <= side_ff[i-1];
      end

      r1_h_ff    <= (in_hue >= HUE_FULL) ? in_hue - HUE_FULL : in_hue;
      r1_s_ff    <= (in_sat > SAT_ONE) ? SAT_ONE : in_sat;
      r1_v_ff    <= in_val;
      r1_zero_ff <= (in_sat == 13'd0);

      r2_sec_ff  <= r2_sec_in;
      r2_rem_ff  <= r2_rem_in[11:0];
      r2_s_ff    <= r1_s_ff;
      r2_sinv_ff <= SAT_ONE - r1_s_ff;
      r2_v_ff    <= r1_v_ff;
      r2_zero_ff <= r1_zero_ff;

      r3_pq_ff   <= {12'd0, r2_s_ff} * {13'd0, r2_rem_ff};
      r3_pt_ff   <= {12'd0, r2_s_ff} * {13'd0, HUE_UNIT - r2_rem_ff};
      r3_pn_ff   <= {13'd0, r2_v_ff} * {8'd0, r2_sinv_ff};
      r3_sec_ff  <= r2_sec_ff;
      r3_v_ff    <= r2_v_ff;
      r3_zero_ff <= r2_zero_ff;

      r4_dq_ff   <= RGB_DEN - r3_pq_ff[23:0];
      r4_dt_ff   <= RGB_DEN - r3_pt_ff[23:0];
      r4_p_ff    <= r4_pn_in[19:12];
      r4_v_ff    <= r3_v_ff;
      r4_sec_ff  <= r3_sec_ff;
      r4_zero_ff <= r3_zero_ff;

      r5_xq_ff   <= {24'd0, r4_v_ff} * {8'd0, r4_dq_ff};
      r5_xt_ff   <= {24'd0, r4_v_ff} * {8'd0, r4_dt_ff};
      r5_p_ff    <= r4_p_ff;
      r5_v_ff    <= r4_v_ff;
      r5_sec_ff  <= r4_sec_ff;
      r5_zero_ff <= r4_zero_ff;

      r6_nq_ff   <= r6_sq_in[31:20];
      r6_nt_ff   <= r6_st_in[31:20];
      r6_p_ff    <= r5_p_ff;
      r6_v_ff    <= r5_v_ff;
      r6_sec_ff  <= r5_sec_ff;
      r6_zero_ff <= r5_zero_ff;

      r7_q_ff    <= r7_mq_in[26:19];
      r7_t_ff    <= r7_mt_in[26:19];
      r7_p_ff    <= r6_p_ff;
      r7_v_ff    <= r6_v_ff;
      r7_sec_ff  <= r6_sec_ff;
      r7_zero_ff <= r6_zero_ff;

      r8_r_ff    <= r8_r_in;
      r8_g_ff    <= r8_g_in;
      r8_b_ff    <= r8_b_in;
   end

   assign out_vld   = vld_ff[RGB_STAGES-1];
   assign out_side  = side_ff[RGB_STAGES-1];
   assign out_red   = r8_r_ff;
   assign out_green = r8_g_ff;
   assign out_blue  = r8_b_ff;

endmodule

// ----- design/rgb_hsv_convert_and_brighten_core.sv -----
// Channel   Ports                                       Handshake
// input     req_first_in, req_second_in, req_third_in   start high, busy low
// result    rsp_first_out, rsp_second_out,              rsp_valid, one cycle
//           rsp_third_out, rsp_hue_undefined
// config    csr_index, csr_wdata                        csr_we
//
// One item is accepted in every cycle in which start is high; busy is always low.
// The pipeline holds three front stages, the 13-stage divider with one
// quotient bit per stage, two hue and gain stages, eight stages of the
// HSV to RGB unit and the output register.
// Reset clears the valid bits and loads mode 0 and gain 1.0; items in flight
// are dropped. The receiver cannot stall, so the pipeline never holds.
module rgb_hsv_convert_and_brighten_core import rhb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [14:0] req_first_in,
   input  logic [12:0] req_second_in,
   input  logic [7:0]  req_third_in,
   output logic        rsp_valid,
   output logic [14:0] rsp_first_out,
   output logic [12:0] rsp_second_out,
   output logic [7:0]  rsp_third_out,
   output logic        rsp_hue_undefined,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // Register stages from the accepting edge to the edge that accepts the result.
   localparam int LATENCY = 3 + DIV_QUO_W + 2 + RGB_STAGES + 1;

   logic        in_fire;
   logic [1:0]  mode_ff;
   logic [15:0] gain_ff;

   // Stage A: register the item, red and green saturated to 8 bits.
   logic        a_vld_ff;
   logic [1:0]  a_mode_ff;
   logic [14:0] a_x_ff;
   logic [12:0] a_y_ff;
   logic [7:0]  a_z_ff, a_r_ff, a_g_ff;

   // Stage B: maximum, minimum and the hue sector operands.
   logic        b_vld_ff;
   logic [1:0]  b_mode_ff, b_base_ff, b_base_in;
   logic [14:0] b_x_ff;
   logic [12:0] b_y_ff;
   logic [7:0]  b_z_ff, b_mx_ff, b_mn_ff, b_hi_ff, b_lo_ff;
   logic [7:0]  b_mx_in, b_mn_in, b_hi_in, b_lo_in, mx_rg, mn_rg;

   // Stage C: numerators with half the divisor added for rounding.
   logic                 c_vld_ff;
   hsv_side_type         c_side_ff, c_side_in;
   logic [DIV_NUM_W-1:0] c_num_s_ff, c_num_h_ff, c_num_s_in, c_num_h_in;
   logic [DIV_DEN_W-1:0] c_den_s_ff, c_den_h_ff;
   logic [7:0]           c_d_in, c_diff_in;
   logic [20:0]          c_diff_w;

   // Divider results.
   logic                 q_vld;
   logic [DIV_QUO_W-1:0] q_sat, q_off;
   logic [$bits(hsv_side_type)-1:0] q_side_bits;
   hsv_side_type         q_side;

   // Stage D: hue finished, value times gain.
   logic        d_vld_ff, d_grey_ff;
   logic [1:0]  d_mode_ff;
   logic [14:0] d_h_ff, d_x_ff, d_h_in;
   logic [12:0] d_s_ff, d_y_ff;
   logic [7:0]  d_v_ff, d_z_ff;
   logic [23:0] d_vg_ff;
   logic [15:0] d_hv_in;

   // Stage E: operands of the HSV to RGB unit chosen by mode.
   logic         e_vld_ff;
   logic [14:0]  e_h_ff, e_h_in;
   logic [12:0]  e_s_ff, e_s_in;
   logic [7:0]   e_v_ff, e_v_in, e_vsat_in;
   logic [24:0]  e_vr_in;
   pix_side_type e_side_ff, e_side_in;

   // HSV to RGB results.
   logic         g_vld;
   logic [7:0]   g_red, g_green, g_blue;
   pix_side_type g_side;

   // Output register.
   logic        out_vld_ff;
   logic [1:0]  out_mode_ff;
   logic [14:0] out_first_ff, out_first_in;
   logic [12:0] out_second_ff, out_second_in;
   logic [7:0]  out_third_ff, out_third_in;
   logic        out_flag_ff, out_flag_in;

   assign busy    = 1'b0;
   assign in_fire = start && !busy;

   // The user writes configuration registers only while the pipeline is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TO_HSV;
         gain_ff <= 16'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[1:0];
            CSR_GAIN: gain_ff <= csr_wdata;
            default:  mode_ff <= mode_ff;
         endcase
      end
   end

   // Stage B logic. Red wins ties for the maximum, then green, then blue.
   assign mx_rg   = (a_g_ff > a_r_ff) ? a_g_ff : a_r_ff;
   assign b_mx_in = (a_z_ff > mx_rg) ? a_z_ff : mx_rg;
   assign mn_rg   = (a_g_ff < a_r_ff) ? a_g_ff : a_r_ff;
   assign b_mn_in = (a_z_ff < mn_rg) ? a_z_ff : mn_rg;

   always_comb begin
      if (a_r_ff == b_mx_in) begin
         b_base_in = BASE_RED;
         b_hi_in   = a_g_ff;
         b_lo_in   = a_z_ff;
      end else if (a_g_ff == b_mx_in) begin
         b_base_in = BASE_GREEN;
         b_hi_in   = a_z_ff;
         b_lo_in   = a_r_ff;
      end else begin
         b_base_in = BASE_BLUE;
         b_hi_in   = a_r_ff;
         b_lo_in   = a_g_ff;
      end
   end

   // Stage C logic. The hue offset is |hi - lo| * 3840 / d; the multiply by
   // 3840 is done as a shift and subtract. A grey pixel divides by zero
   // here, and its quotients are thrown away later.
   assign c_d_in    = b_mx_ff - b_mn_ff;
   assign c_diff_in = (b_lo_ff > b_hi_ff) ? b_lo_ff - b_hi_ff : b_hi_ff - b_lo_ff;
   assign c_diff_w  = {13'd0, c_diff_in};
   assign c_num_h_in = (c_diff_w << 12) - (c_diff_w << 8) + {14'd0, c_d_in[7:1]};
   assign c_num_s_in = {1'b0, c_d_in, 12'd0} + {14'd0, b_mx_ff[7:1]};

   always_comb begin
      c_side_in.mode = b_mode_ff;
      c_side_in.grey = (c_d_in == 8'd0);
      c_side_in.val  = b_mx_ff;
      c_side_in.base = b_base_ff;
      c_side_in.neg  = (b_lo_ff > b_hi_ff);
      c_side_in.x    = b_x_ff;
      c_side_in.y    = b_y_ff;
      c_side_in.z    = b_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_fire;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
      a_mode_ff <= mode_ff;
      a_x_ff    <= req_first_in;
      a_y_ff    <= req_second_in;
      a_z_ff    <= req_third_in;
      a_r_ff    <= (req_first_in > 15'd255) ? 8'd255 : req_first_in[7:0];
      a_g_ff    <= (req_second_in > 13'd255) ? 8'd255 : req_second_in[7:0];

      b_mode_ff <= a_mode_ff;
      b_x_ff    <= a_x_ff;
      b_y_ff    <= a_y_ff;
      b_z_ff    <= a_z_ff;
      b_mx_ff   <= b_mx_in;
      b_mn_ff   <= b_mn_in;
      b_base_ff <= b_base_in;
      b_hi_ff   <= b_hi_in;
      b_lo_ff   <= b_lo_in;

      c_side_ff  <= c_side_in;
      c_num_s_ff <= c_num_s_in;
      c_num_h_ff <= c_num_h_in;
      c_den_s_ff <= b_mx_ff;
      c_den_h_ff <= c_d_in;
   end

   rhb_div_pipe #(
      .PW ($bits(hsv_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (c_vld_ff),
      .in_num_a  (c_num_s_ff),
      .in_den_a  (c_den_s_ff),
      .in_num_b  (c_num_h_ff),
      .in_den_b  (c_den_h_ff),
      .in_side   (c_side_ff),
      .out_vld   (q_vld),
      .out_quo_a (q_sat),
      .out_quo_b (q_off),
      .out_side  (q_side_bits)
   );

   assign q_side = hsv_side_type'(q_side_bits);

   // Stage D logic. A negative offset wraps by the full circle; the sum stays
   // below two circles, so one compare and subtract reduces it.
   assign d_hv_in = q_side.neg ?
                    {1'b0, hue_base(q_side.base)} + {1'b0, HUE_FULL} - {3'd0, q_off}
                  : {1'b0, hue_base(q_side.base)} + {3'd0, q_off};
   assign d_h_in  = (d_hv_in >= {1'b0, HUE_FULL}) ? 15'(d_hv_in - {1'b0, HUE_FULL})
                                                  : d_hv_in[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= q_vld;
      end
      d_mode_ff <= q_side.mode;
      d_grey_ff <= q_side.grey;
      d_h_ff    <= q_side.grey ? 15'd0 : d_h_in;
      d_s_ff    <= q_side.grey ? 13'd0 : q_sat;
      d_v_ff    <= q_side.val;
      d_vg_ff   <= {16'd0, q_side.val} * {8'd0, gain_ff};
      d_x_ff    <= q_side.x;
      d_y_ff    <= q_side.y;
      d_z_ff    <= q_side.z;
   end

   // Stage E logic. The brightened value is rounded and saturated at 255.
   assign e_vr_in   = {1'b0, d_vg_ff} + 25'd128;
   assign e_vsat_in = (e_vr_in[24:16] != 9'd0) ? 8'd255 : e_vr_in[15:8];

   always_comb begin
      e_side_in.mode = d_mode_ff;
      e_side_in.hue  = d_h_ff;
      e_side_in.sat  = d_s_ff;
      e_side_in.val  = d_v_ff;
      case (d_mode_ff)
         MODE_TO_RGB: begin
            e_h_in = d_x_ff;
            e_s_in = d_y_ff;
            e_v_in = d_z_ff;
            e_side_in.flag = (d_y_ff == 13'd0);
         end
         MODE_BRIGHTEN: begin
            e_h_in = d_h_ff;
            e_s_in = d_s_ff;
            e_v_in = e_vsat_in;
            e_side_in.flag = d_grey_ff;
         end
         MODE_TO_HSV: begin
            e_h_in = d_h_ff;
            e_s_in = d_s_ff;
            e_v_in = d_v_ff;
            e_side_in.flag = d_grey_ff;
         end
         default: begin
            e_h_in = d_h_ff;
            e_s_in = d_s_ff;
            e_v_in = d_v_ff;
            e_side_in.flag = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
      e_h_ff    <= e_h_in;
      e_s_ff    <= e_s_in;
      e_v_ff    <= e_v_in;
      e_side_ff <= e_side_in;
   end

   rhb_hsv2rgb u_hsv2rgb (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (e_vld_ff),
      .in_hue    (e_h_ff),
      .in_sat    (e_s_ff),
      .in_val    (e_v_ff),
      .in_side   (e_side_ff),
      .out_vld   (g_vld),
      .out_red   (g_red),
      .out_green (g_green),
      .out_blue  (g_blue),
      .out_side  (g_side)
   );

   // Output selection: HSV fields in mode 0, RGB in modes 1 and 2, and an
   // all-zero item for the unused mode.
   always_comb begin
      case (g_side.mode)
         MODE_TO_HSV: begin
            out_first_in  = g_side.hue;
            out_second_in = g_side.sat;
            out_third_in  = g_side.val;
            out_flag_in   = g_side.flag;
         end
         MODE_TO_RGB, MODE_BRIGHTEN: begin
            out_first_in  = {7'd0, g_red};
            out_second_in = {5'd0, g_green};
            out_third_in  = g_blue;
            out_flag_in   = g_side.flag;
         end
         default: begin
            out_first_in  = 15'd0;
            out_second_in = 13'd0;
            out_third_in  = 8'd0;
            out_flag_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= g_vld;
      end
      out_mode_ff   <= g_side.mode;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_third_ff  <= out_third_in;
      out_flag_ff   <= out_flag_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_first_out     = out_first_ff;
   assign rsp_second_out    = out_second_ff;
   assign rsp_third_out     = out_third_ff;
   assign rsp_hue_undefined = out_flag_ff;

   // Every accepted item comes out after the fixed latency.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      in_fire |-> ##LATENCY rsp_valid)
      else $error("accepted item did not produce a result on time");

   // No result appears without an item accepted the latency before.
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_fire, LATENCY))
      else $error("result without a matching accepted item");

   // A grey pixel converted to HSV has zero saturation.
   a_grey_hsv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hue_undefined && out_mode_ff == MODE_TO_HSV)
      |-> (rsp_second_out == 13'd0))
      else $error("grey pixel with nonzero saturation");

   // A grey pixel converted to RGB has three equal channels.
   a_grey_rgb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hue_undefined &&
       (out_mode_ff == MODE_TO_RGB || out_mode_ff == MODE_BRIGHTEN))
      |-> (rsp_first_out == {7'd0, rsp_third_out} &&
           rsp_second_out == {5'd0, rsp_third_out}))
      else $error("grey pixel with unequal color channels");

endmodule
